@@ rtl/core/blir_pkg.sv @@
// Shared types, defaults and constants for the linear interpolation resampler.
package blir_pkg;

  localparam int IN_BLOCK_DEF  = 2100;
  localparam int OUT_BLOCK_DEF = 2048;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SAMPLE_W      = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t sample_i;
    sample_t sample_q;
  } in_item_t;

  typedef struct packed {
    sample_t out_i;
    sample_t out_q;
    logic    block_end;
  } out_item_t;

  // Per-item decision from the phase tracker.
  typedef struct packed {
    logic emit;
    logic last;
  } step_t;

endpackage

@@ rtl/core/blir_lerp.sv @@
// One-channel linear blend: a*(1-w) + b*w with round-half-up, w in FRAC_BITS fixed point.
module blir_lerp #(
  parameter int FRAC_BITS = blir_pkg::FRAC_BITS_DEF
) (
  input  blir_pkg::sample_t a,
  input  blir_pkg::sample_t b,
  input  logic [FRAC_BITS:0] weight,
  output blir_pkg::sample_t  y
);

  localparam int DIFF_W = blir_pkg::SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int ACC_W  = PROD_W + 1;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // a*2^F + (b-a)*w + half, then floor shift; the result is a convex combination
  assign diff = DIFF_W'(b) - DIFF_W'(a);
  assign prod = PROD_W'(diff) * $signed({1'b0, weight});
  assign acc  = (ACC_W'(a) <<< FRAC_BITS) + ACC_W'(prod)
              + (ACC_W'(1) <<< (FRAC_BITS - 1));
  assign y    = acc[FRAC_BITS +: blir_pkg::SAMPLE_W];

endmodule

@@ rtl/core/blir_phase.sv @@
// Slot and output-position tracker; keeps the interpolation weight incrementally.
module blir_phase #(
  parameter int IN_BLOCK  = blir_pkg::IN_BLOCK_DEF,
  parameter int OUT_BLOCK = blir_pkg::OUT_BLOCK_DEF,
  parameter int FRAC_BITS = blir_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  output blir_pkg::step_t      step,
  output logic [FRAC_BITS:0]   weight
);

  localparam int SLOT_W = $clog2(IN_BLOCK + 1);
  localparam int CNT_W  = $clog2(OUT_BLOCK + 1);
  localparam int REM_W  = $clog2(OUT_BLOCK);
  localparam int WGT_W  = FRAC_BITS + 1;
  localparam int ACC_W  = FRAC_BITS + 14;
  localparam int KQ     = IN_BLOCK / OUT_BLOCK;
  localparam int KR     = IN_BLOCK % OUT_BLOCK;
  localparam longint unsigned QA = (64'(IN_BLOCK) << FRAC_BITS) / OUT_BLOCK;
  localparam longint unsigned RA = (64'(IN_BLOCK) << FRAC_BITS) % OUT_BLOCK;
  localparam int E_INIT = OUT_BLOCK / 2;

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] base_r, base_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [REM_W-1:0]  err_r, err_nxt;
  logic [WGT_W-1:0]  weight_r, weight_nxt;

  logic [REM_W:0]    rsum, rdiff, esum, ediff;
  logic              rc, ec, wrap;
  logic [ACC_W-1:0]  wsum, kterm, wdiff;

  // weight = round(rem * 2^F / OUT_BLOCK) kept as quotient weight_r and remainder err_r
  assign rsum  = {1'b0, rem_r} + (REM_W+1)'(KR);
  assign rc    = rsum >= (REM_W+1)'(OUT_BLOCK);
  assign rdiff = rsum - (REM_W+1)'(OUT_BLOCK);
  assign esum  = {1'b0, err_r} + (REM_W+1)'(RA);
  assign ec    = esum >= (REM_W+1)'(OUT_BLOCK);
  assign ediff = esum - (REM_W+1)'(OUT_BLOCK);
  assign wsum  = ACC_W'(weight_r) + ACC_W'(QA) + ACC_W'(ec);
  assign kterm = ACC_W'(KQ) + ACC_W'(rc);
  assign wdiff = wsum - (kterm << FRAC_BITS);

  assign step.emit = (count_r < CNT_W'(OUT_BLOCK))
                  && ({1'b0, slot_r} == ({1'b0, base_r} + (SLOT_W+1)'(1)));
  assign step.last = count_r == CNT_W'(OUT_BLOCK - 1);
  assign wrap      = slot_r >= SLOT_W'(IN_BLOCK);
  assign weight    = weight_r;

  always_comb begin
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    base_nxt   = base_r;
    rem_nxt    = rem_r;
    err_nxt    = err_r;
    weight_nxt = weight_r;
    if (advance) begin
      if (step.emit) begin
        count_nxt  = count_r + CNT_W'(1);
        base_nxt   = base_r + SLOT_W'(KQ) + SLOT_W'(rc);
        rem_nxt    = rc ? rdiff[REM_W-1:0] : rsum[REM_W-1:0];
        err_nxt    = ec ? ediff[REM_W-1:0] : esum[REM_W-1:0];
        weight_nxt = wdiff[WGT_W-1:0];
      end
      if (wrap) begin
        slot_nxt   = SLOT_W'(1);
        count_nxt  = '0;
        base_nxt   = '0;
        rem_nxt    = '0;
        err_nxt    = REM_W'(E_INIT);
        weight_nxt = '0;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      count_r  <= '0;
      base_r   <= '0;
      rem_r    <= '0;
      err_r    <= REM_W'(E_INIT);
      weight_r <= '0;
    end else begin
      slot_r   <= slot_nxt;
      count_r  <= count_nxt;
      base_r   <= base_nxt;
      rem_r    <= rem_nxt;
      err_r    <= err_nxt;
      weight_r <= weight_nxt;
    end
  end

`ifndef SYNTHESIS
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    weight_r <= (WGT_W'(1) << FRAC_BITS))
    else $error("interpolation weight above one");
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, err_r} < (REM_W+1)'(OUT_BLOCK)) && ({1'b0, rem_r} < (REM_W+1)'(OUT_BLOCK)))
    else $error("phase remainder out of range");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(OUT_BLOCK))
    else $error("output count beyond block");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && wrap) |=> (count_r == '0) && (slot_r == SLOT_W'(1)))
    else $error("block wrap did not restart the tracker");
`endif

endmodule

@@ rtl/core/block_linear_interp_resampler_core.sv @@
// Top level of the linear interpolation resampler: handshake, item stage and result register.
// A completing item passes through the item stage and then the result register.
// Up to one result per item; one item and one result per cycle unless out_ready stalls.
// The weight is tracked incrementally, so the path is one multiply-add per channel.
// Reset (rst_n low, synchronous) clears the slot and phase tracker, both valid flags and
// the previous-sample register; the block takes items in the first cycle after reset.
module block_linear_interp_resampler_core #(
  parameter int IN_BLOCK  = blir_pkg::IN_BLOCK_DEF,
  parameter int OUT_BLOCK = blir_pkg::OUT_BLOCK_DEF,
  parameter int FRAC_BITS = blir_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  blir_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output blir_pkg::out_item_t out_data
);

  blir_pkg::step_t    step;
  logic [FRAC_BITS:0] weight;
  logic               in_acc, out_free, s1_go;

  // previous sample: slot b when the current item fills slot b+1
  blir_pkg::in_item_t prev_r;

  // item stage: holds only items that produce a result
  logic               s1_valid_r, s1_valid_nxt;
  blir_pkg::in_item_t s1_a_r, s1_b_r;
  logic [FRAC_BITS:0] s1_w_r;
  logic               s1_last_r;

  // result register
  logic                out_valid_r, out_valid_nxt;
  blir_pkg::out_item_t out_data_r;
  blir_pkg::sample_t   blend_i, blend_q;

  // The result register frees when empty or being taken; the item stage drains into it.
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_acc   = in_valid && in_ready;

  blir_phase #(
    .IN_BLOCK  (IN_BLOCK),
    .OUT_BLOCK (OUT_BLOCK),
    .FRAC_BITS (FRAC_BITS)
  ) u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_acc),
    .step    (step),
    .weight  (weight)
  );

  blir_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_i (
    .a      (s1_a_r.sample_i),
    .b      (s1_b_r.sample_i),
    .weight (s1_w_r),
    .y      (blend_i)
  );

  blir_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_q (
    .a      (s1_a_r.sample_q),
    .b      (s1_b_r.sample_q),
    .weight (s1_w_r),
    .y      (blend_q)
  );

  // Drop items that complete no output; hold a waiting one until the result register frees.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = step.emit;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        prev_r <= in_data;
      end
    end
  end

  // Payload registers: capture on accept / advance only.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_a_r    <= prev_r;
      s1_b_r    <= in_data;
      s1_w_r    <= weight;
      s1_last_r <= step.last;
    end
    if (s1_go) begin
      out_data_r.out_i     <= blend_i;
      out_data_r.out_q     <= blend_q;
      out_data_r.block_end <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the linear interpolation resampler core.
module tb;

  // Run the block at its default rate ratio; the predictor uses the same numbers.
  localparam int IN_BLOCK  = blir_pkg::IN_BLOCK_DEF;
  localparam int OUT_BLOCK = blir_pkg::OUT_BLOCK_DEF;
  localparam int FRAC_BITS = blir_pkg::FRAC_BITS_DEF;

  localparam longint ONE_W  = longint'(1) << FRAC_BITS;
  localparam longint HALF_W = ONE_W >> 1;

  localparam blir_pkg::sample_t S_MAX  = 16'sh7fff;
  localparam blir_pkg::sample_t S_MIN  = 16'sh8000;
  localparam blir_pkg::sample_t S_ZERO = 16'sh0000;
  localparam blir_pkg::sample_t S_NEG1 = 16'shffff;

  // Random part: this many items after the directed rows.
  localparam int RAND_ITEMS   = 750;
  localparam int DRAIN_CYCLES = 16;
  // Slowest legal run is under 800 items, each behind a random gap and a random ready
  // stall; this leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  blir_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  blir_pkg::out_item_t out_data;

  block_linear_interp_resampler_core #(
    .IN_BLOCK (IN_BLOCK),
    .OUT_BLOCK(OUT_BLOCK),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Resampler predictor: its own copy of the slot and phase tracker.
  // ---------------------------------------------------------------------------
  blir_pkg::in_item_t rs_prev = '0;   // last sample seen, becomes x[b] of the next blend
  logic [11:0] rs_slot = '0;   // slot the next sample fills
  logic [11:0] rs_outs = '0;   // index of the next output within the block
  logic [11:0] rs_base = '0;   // floor of that output's position
  logic [11:0] rs_rem  = '0;   // its remainder modulo OUT_BLOCK

  blir_pkg::out_item_t pending_outs [$];  // interpolated samples still owed by the block

  // Weighted sum a*(1-w) + b*w, rounded half up and floored by arithmetic shift.
  function automatic blir_pkg::sample_t mix(input blir_pkg::sample_t a,
                                            input blir_pkg::sample_t b, input longint w);
    longint acc;
    acc = longint'(a) * (ONE_W - w) + longint'(b) * w + HALF_W;
    return blir_pkg::sample_t'(acc >>> FRAC_BITS);
  endfunction

  // Advance the tracker by one accepted sample; return 1 when it completes an output.
  function automatic bit interp_step(input blir_pkg::in_item_t x,
                                     output blir_pkg::out_item_t y);
    longint      w;
    int unsigned sum;
    bit          fire;
    fire = (rs_outs < OUT_BLOCK) && (rs_slot == rs_base + 1);
    y = '0;
    if (fire) begin
      w = ((longint'(rs_rem) << FRAC_BITS) + OUT_BLOCK / 2) / OUT_BLOCK;
      y.out_i     = mix(rs_prev.sample_i, x.sample_i, w);
      y.out_q     = mix(rs_prev.sample_q, x.sample_q, w);
      y.block_end = (rs_outs == OUT_BLOCK - 1);
      rs_outs++;
      sum     = rs_rem + IN_BLOCK;
      rs_base = 12'(rs_base + sum / OUT_BLOCK);
      rs_rem  = 12'(sum % OUT_BLOCK);
    end
    rs_prev = x;
    // Block wrap: the sample in the last slot is carried as slot 0 of the next block.
    if (rs_slot >= IN_BLOCK) begin
      rs_slot = 12'd1;
      rs_outs = '0;
      rs_base = '0;
      rs_rem  = '0;
    end else begin
      rs_slot++;
    end
    return fire;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed rows, one per slot from reset. Where both neighbors are the same
  // value, or the weight is zero (first output of a block), the result is known
  // outright and typed in; every other row goes through the predictor.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    blir_pkg::sample_t si;
    blir_pkg::sample_t sq;
    logic              known;
    blir_pkg::sample_t ei;
    blir_pkg::sample_t eq;
    logic              eend;
  } dir_row_t;

  localparam int N_DIR = 18;
  dir_row_t dir_rows [N_DIR] = '{
    '{S_MAX,  S_MIN,  1'b0, S_ZERO, S_ZERO, 1'b0},  // slot 0: nothing comes out
    '{S_ZERO, S_ZERO, 1'b1, S_MAX,  S_MIN,  1'b0},  // zero weight: previous sample
    '{S_MAX,  S_MIN,  1'b0, S_ZERO, S_ZERO, 1'b0},
    '{S_MAX,  S_MIN,  1'b1, S_MAX,  S_MIN,  1'b0},  // equal extremes stay put
    '{S_MIN,  S_MAX,  1'b0, S_ZERO, S_ZERO, 1'b0},  // full-scale swing
    '{S_MIN,  S_MAX,  1'b1, S_MIN,  S_MAX,  1'b0},
    '{S_MAX,  S_MIN,  1'b0, S_ZERO, S_ZERO, 1'b0},
    '{S_NEG1, S_NEG1, 1'b0, S_ZERO, S_ZERO, 1'b0},
    '{S_NEG1, S_NEG1, 1'b1, S_NEG1, S_NEG1, 1'b0},
    '{S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO, 1'b0},
    '{S_ZERO, S_ZERO, 1'b1, S_ZERO, S_ZERO, 1'b0},
    '{16'sh0001, S_NEG1, 1'b0, S_ZERO, S_ZERO, 1'b0},
    '{16'sh5555, 16'shaaaa, 1'b0, S_ZERO, S_ZERO, 1'b0},
    '{16'shaaaa, 16'sh5555, 1'b0, S_ZERO, S_ZERO, 1'b0},
    '{S_MIN,  S_MIN,  1'b0, S_ZERO, S_ZERO, 1'b0},
    '{S_MIN,  S_MIN,  1'b1, S_MIN,  S_MIN,  1'b0},
    '{S_MAX,  S_MAX,  1'b0, S_ZERO, S_ZERO, 1'b0},
    '{S_MAX,  S_MAX,  1'b1, S_MAX,  S_MAX,  1'b0}
  };

  blir_pkg::sample_t corners [4] = '{S_MAX, S_MIN, S_ZERO, S_NEG1};

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps; a quarter of the
  // bursts follow the previous one back to back.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_sample(input blir_pkg::in_item_t x);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    // Hold valid and payload until the block takes the item.
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait out every owed result; always wait on the clock before testing,
  // so valid is never lowered and raised in the same step.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_outs.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a 32-bit pattern, reloaded once all its bits are used; the
  // pattern is sometimes all ones, sometimes dense, sometimes sparse.
  // ---------------------------------------------------------------------------
  logic [31:0] ready_pat = '1;
  logic [4:0]  ready_bit = '0;

  always @(posedge clk) begin
    out_ready <= ready_pat[ready_bit];
    ready_bit <= ready_bit + 5'd1;
    if (ready_bit == 5'd31) begin
      case ($urandom_range(0, 3))
        0:       ready_pat <= '1;
        1:       ready_pat <= $urandom;
        2:       ready_pat <= ($urandom & $urandom) | 32'h1;
        default: ready_pat <= $urandom | $urandom;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted item with the oldest expectation.
  // ---------------------------------------------------------------------------
  int unsigned         errors = 0;
  blir_pkg::out_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_outs.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: i %0d q %0d end %0b",
                   out_data.out_i, out_data.out_q, out_data.block_end);
      end else begin
        want = pending_outs.pop_front();
        if (out_data.out_i !== want.out_i || out_data.out_q !== want.out_q ||
            out_data.block_end !== want.block_end) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected i %0d q %0d end %0b, got i %0d q %0d end %0b",
                     want.out_i, want.out_q, want.block_end,
                     out_data.out_i, out_data.out_q, out_data.block_end);
        end
      end
    end
  end

  // Watchdog.
  int unsigned cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL block_linear_interp_resampler_core");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    blir_pkg::in_item_t  x;
    blir_pkg::in_item_t  last_sent;
    blir_pkg::out_item_t y;
    blir_pkg::out_item_t typed;
    bit                  fired;
    int unsigned         rand_items;

    last_sent  = '0;
    rand_items = 0;

    // Hold reset low, then release it on an edge.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: extremes, full swings and the zero-weight first output.
    for (int k = 0; k < N_DIR; k++) begin
      x.sample_i = dir_rows[k].si;
      x.sample_q = dir_rows[k].sq;
      send_sample(x);
      fired = interp_step(x, y);
      typed.out_i     = dir_rows[k].ei;
      typed.out_q     = dir_rows[k].eq;
      typed.block_end = dir_rows[k].eend;
      if (dir_rows[k].known)
        pending_outs.push_back(typed);
      else if (fired)
        pending_outs.push_back(y);
      last_sent = x;
    end

    // Pause the sender until the block has caught up completely.
    hold_until_drained();

    // Random stream: mostly random words, some extremes, some slow-moving signal.
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 9)) inside
        [0:4]: x = blir_pkg::in_item_t'($urandom);
        [5:6]: begin
          x.sample_i = corners[$urandom_range(0, 3)];
          x.sample_q = corners[$urandom_range(0, 3)];
        end
        default: begin
          x.sample_i = last_sent.sample_i
                     + blir_pkg::sample_t'($urandom_range(0, 512) - 256);
          x.sample_q = last_sent.sample_q
                     + blir_pkg::sample_t'($urandom_range(0, 512) - 256);
        end
      endcase
      send_sample(x);
      if (interp_step(x, y))
        pending_outs.push_back(y);
      last_sent = x;
      rand_items++;
      if ($urandom_range(0, 299) == 0)
        hold_until_drained();
    end

    // Let every owed result arrive, then allow for the pipeline to settle.
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_outs.size() == 0)
      $display("PASS block_linear_interp_resampler_core");
    else
      $display("FAIL block_linear_interp_resampler_core");
    $finish;
  end

endmodule
